[hw/rtl/tile_record_stream_parser_top_defines.svh]
// Assertion macros for the tile record stream parser.
// Expects clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef TILE_RECORD_STREAM_PARSER_TOP_DEFINES_SVH
`define TILE_RECORD_STREAM_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TRSP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("trsp assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define TRSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("trsp assertion failed");

`endif

[hw/rtl/trsp_pkg.sv]
// Types, codes and constants of the tile record stream parser.
// Used by every module of the block; no dependencies.
package trsp_pkg;

  localparam int unsigned SizeBitsDef  = 24;
  localparam int unsigned IndexBitsDef = 16;

  localparam logic [16:0] TileBytesReset = 17'd16384;

  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChL     = 8'h4C;
  localparam logic [7:0] ChZ     = 8'h5A;
  localparam logic [7:0] ChF     = 8'h46;

  localparam logic [7:0] FlagRaw = 8'h00;
  localparam logic [7:0] FlagLzf = 8'h01;

  typedef enum logic {
    REG_TARGET_TILE = 1'b0,
    REG_TILE_BYTES  = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_PARSE    = 3'd1,
    ST_FLAG     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_TRUNC    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_X    = 3'd0,
    PH_Y    = 3'd1,
    PH_TAG  = 3'd2,
    PH_SIZE = 3'd3,
    PH_SKIP = 3'd4,
    PH_FLAG = 3'd5,
    PH_DATA = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    NUM_CONT = 2'd0,
    NUM_ERR  = 2'd1,
    NUM_END  = 2'd2
  } num_res_e;

  typedef struct packed {
    logic [15:0] target_tile;
    logic [16:0] tile_bytes;
  } cfg_t;

  typedef struct packed {
    logic               has_byte;
    logic [7:0]         payload_byte;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               compressed;
    status_e            status;
    logic               last;
  } result_t;

  function automatic logic [7:0] tag_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = ChL;
      2'd1:    c = ChZ;
      2'd2:    c = ChF;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    return (b == ChComma) || (b == ChNl);
  endfunction

endpackage

[hw/rtl/trsp_cfg.sv]
// Configuration registers of the tile record stream parser on an APB-style port.
// Depends on trsp_pkg.
module trsp_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output trsp_pkg::cfg_t     cfg_o
);
  import trsp_pkg::*;

  logic [15:0] target_tile_q;
  logic [16:0] tile_bytes_q;
  logic        wr_en;
  reg_idx_e    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_tile_q <= 16'd0;
      tile_bytes_q  <= TileBytesReset;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TARGET_TILE: target_tile_q <= pwdata[15:0];
        REG_TILE_BYTES:  tile_bytes_q  <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TARGET_TILE: prdata = {16'd0, target_tile_q};
      REG_TILE_BYTES:  prdata = {15'd0, tile_bytes_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o.target_tile = target_tile_q;
  assign cfg_o.tile_bytes  = tile_bytes_q;

endmodule

[hw/rtl/trsp_step.sv]
// Parse state and per-byte step logic of the tile record stream parser.
// Depends on trsp_pkg.
module trsp_step #(
  parameter int unsigned SIZE_BITS  = trsp_pkg::SizeBitsDef,
  parameter int unsigned INDEX_BITS = trsp_pkg::IndexBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  trsp_pkg::cfg_t    cfg_i,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              first_byte_i,
  input  logic              final_byte_i,
  output logic              res_valid_o,
  output trsp_pkg::result_t res_o
);
  import trsp_pkg::*;

  localparam int unsigned LeftW = (SIZE_BITS > 17) ? SIZE_BITS : 17;
  localparam logic [35:0] SizeLimit = (36'd1 << SIZE_BITS) - 36'd1;

  phase_e                phase_q, c_phase, n_phase;
  logic [31:0]           acc_q, c_acc, n_acc;
  logic                  neg_q, c_neg, n_neg;
  logic                  dd_q, c_dd, n_dd;
  logic                  ff_q, c_ff, n_ff;
  logic [1:0]            tag_q, c_tag, n_tag;
  logic [31:0]           x_q, c_x, n_x;
  logic [31:0]           y_q, c_y, n_y;
  logic [INDEX_BITS-1:0] cnt_q, c_cnt, n_cnt;
  logic [LeftW-1:0]      left_q, c_left, n_left;
  logic                  fin_q, c_fin, n_fin;
  logic                  cmp_q, c_cmp, n_cmp;

  logic        is_digit;
  logic [3:0]  dval;
  logic [35:0] acc_ext, acc_x10;
  logic [35:0] num_limit;
  num_res_e    num_res;
  logic [31:0] num_acc;
  logic        num_neg, num_dd, num_ff;
  logic [31:0] signed_val;

  status_e err, fin_st;
  logic    have, done_ok, produce, tgt;

  always_comb begin
    if (first_byte_i) begin
      c_phase = PH_X;   c_acc = 32'd0; c_neg = 1'b0; c_dd = 1'b0; c_ff = 1'b1;
      c_tag   = 2'd0;   c_x   = 32'd0; c_y   = 32'd0;
      c_cnt   = '0;     c_left = '0;   c_fin = 1'b0; c_cmp = 1'b0;
    end else begin
      c_phase = phase_q; c_acc = acc_q; c_neg = neg_q; c_dd = dd_q; c_ff = ff_q;
      c_tag   = tag_q;   c_x   = x_q;   c_y   = y_q;
      c_cnt   = cnt_q;   c_left = left_q; c_fin = fin_q; c_cmp = cmp_q;
    end
  end

  assign is_digit = (data_byte_i >= ChZero) && (data_byte_i <= ChNine);
  assign dval     = 4'(data_byte_i - ChZero);
  assign acc_ext  = {4'd0, c_acc};
  assign acc_x10  = (acc_ext << 3) + (acc_ext << 1) + {32'd0, dval};
  assign num_limit = (c_phase == PH_SIZE) ? SizeLimit
                   : (c_neg ? 36'h080000000 : 36'h07FFFFFFF);
  assign signed_val = c_neg ? (32'd0 - c_acc) : c_acc;

  always_comb begin
    num_res = NUM_CONT;
    num_acc = c_acc;
    num_neg = c_neg;
    num_dd  = c_dd;
    num_ff  = c_ff;
    if (c_ff) begin
      if (is_digit) begin
        num_acc = {28'd0, dval};
        num_ff  = 1'b0;
      end else if (data_byte_i == ChMinus && c_phase != PH_SIZE && !c_neg) begin
        num_neg = 1'b1;
      end else begin
        num_res = NUM_ERR;
      end
    end else if (is_sep(data_byte_i)) begin
      num_res = NUM_END;
    end else if (!c_dd) begin
      if (is_digit) begin
        if (acc_x10 > num_limit) num_res = NUM_ERR;
        else                     num_acc = acc_x10[31:0];
      end else begin
        num_dd = 1'b1;
      end
    end
  end

  always_comb begin
    n_phase = c_phase; n_acc = c_acc; n_neg = c_neg; n_dd = c_dd; n_ff = c_ff;
    n_tag   = c_tag;   n_x   = c_x;   n_y   = c_y;
    n_cnt   = c_cnt;   n_left = c_left; n_fin = c_fin; n_cmp = c_cmp;
    err     = ST_OK;
    have    = 1'b0;
    done_ok = 1'b0;
    if (!c_fin) begin
      case (c_phase)
        PH_X, PH_Y: begin
          n_acc = num_acc; n_neg = num_neg; n_dd = num_dd; n_ff = num_ff;
          if (num_res == NUM_ERR) begin
            err = ST_PARSE;
          end else if (num_res == NUM_END) begin
            if (c_phase == PH_X) begin
              n_x     = signed_val;
              n_phase = PH_Y;
            end else begin
              n_y     = signed_val;
              n_phase = PH_TAG;
            end
            n_acc = 32'd0; n_neg = 1'b0; n_dd = 1'b0; n_ff = 1'b1; n_tag = 2'd0;
          end
        end
        PH_TAG: begin
          if (c_ff) begin
            n_ff = 1'b0;
            if (data_byte_i != ChL) err = ST_PARSE;
            else                    n_tag = 2'd1;
          end else if (is_sep(data_byte_i)) begin
            if (c_tag == 2'd3) begin
              n_phase = PH_SIZE;
              n_acc = 32'd0; n_neg = 1'b0; n_dd = 1'b0; n_ff = 1'b1; n_tag = 2'd0;
            end else begin
              err = ST_PARSE;
            end
          end else if (c_tag == 2'd3 || data_byte_i != tag_char(c_tag)) begin
            err = ST_PARSE;
          end else begin
            n_tag = c_tag + 2'd1;
          end
        end
        PH_SIZE: begin
          n_acc = num_acc; n_neg = num_neg; n_dd = num_dd; n_ff = num_ff;
          if (num_res == NUM_ERR) begin
            err = ST_PARSE;
          end else if (num_res == NUM_END) begin
            if (c_acc == 32'd0) begin
              err = ST_PARSE;
            end else begin
              n_left = c_acc[LeftW-1:0];
              if (c_cnt == INDEX_BITS'(cfg_i.target_tile)) begin
                n_phase = PH_FLAG;
              end else begin
                n_phase = PH_SKIP;
                n_cnt   = c_cnt + INDEX_BITS'(1);
              end
            end
          end
        end
        PH_SKIP: begin
          n_left = c_left - LeftW'(1);
          if (n_left == '0) begin
            n_phase = PH_X;
            n_acc = 32'd0; n_neg = 1'b0; n_dd = 1'b0; n_ff = 1'b1; n_tag = 2'd0;
          end
        end
        PH_FLAG: begin
          if (data_byte_i == FlagRaw || data_byte_i == FlagLzf) begin
            if (data_byte_i == FlagRaw) begin
              n_cmp  = 1'b0;
              n_left = LeftW'(cfg_i.tile_bytes);
            end else begin
              n_cmp  = 1'b1;
              n_left = c_left - LeftW'(1);
            end
            n_phase = PH_DATA;
            done_ok = (n_left == '0);
          end else begin
            err = ST_FLAG;
          end
        end
        PH_DATA: begin
          have    = 1'b1;
          n_left  = c_left - LeftW'(1);
          done_ok = (n_left == '0);
        end
        default: err = ST_PARSE;
      endcase
    end

    if (n_phase >= PH_FLAG)
      fin_st = ST_TRUNC;
    else if (n_phase == PH_SKIP || (n_phase == PH_X && n_ff && !n_neg))
      fin_st = ST_NOTFOUND;
    else
      fin_st = ST_PARSE;

    tgt     = (n_phase >= PH_FLAG);
    produce = !c_fin && (err != ST_OK || done_ok || final_byte_i || have);
    if (produce && (err != ST_OK || done_ok || final_byte_i)) n_fin = 1'b1;

    res_o.has_byte     = have && err == ST_OK;
    res_o.payload_byte = (have && err == ST_OK) ? data_byte_i : 8'd0;
    res_o.pos_x        = tgt ? n_x : 32'd0;
    res_o.pos_y        = tgt ? n_y : 32'd0;
    res_o.compressed   = tgt && n_cmp;
    if (err != ST_OK)   res_o.status = err;
    else if (done_ok)   res_o.status = ST_OK;
    else if (final_byte_i) res_o.status = fin_st;
    else                res_o.status = ST_OK;
    res_o.last         = err != ST_OK || done_ok || final_byte_i;
  end

  assign res_valid_o = step_i && produce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_X;  acc_q <= 32'd0; neg_q <= 1'b0; dd_q <= 1'b0; ff_q <= 1'b1;
      tag_q   <= 2'd0;  x_q   <= 32'd0; y_q   <= 32'd0;
      cnt_q   <= '0;    left_q <= '0;   fin_q <= 1'b0; cmp_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= n_phase; acc_q <= n_acc; neg_q <= n_neg; dd_q <= n_dd; ff_q <= n_ff;
      tag_q   <= n_tag;   x_q   <= n_x;   y_q   <= n_y;
      cnt_q   <= n_cnt;   left_q <= n_left; fin_q <= n_fin; cmp_q <= n_cmp;
    end
  end

endmodule

[hw/rtl/trsp_out_stage.sv]
// Result register of the tile record stream parser; holds a result under stall.
// Depends on trsp_pkg.
module trsp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  trsp_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output trsp_pkg::result_t res_o
);
  import trsp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[hw/rtl/tile_record_stream_parser_top.sv]
// Path: an input byte passes the input register, then the result register, before any result it yields is transferred.
// Throughput: one byte per cycle while in_stall_o is low; the parse step is one pass of logic per byte.
// Reset: rst_ni clears the pipeline valids and parse state and resets the configuration registers to their defaults.
// Top level of the tile record stream parser.
// Depends on trsp_pkg, trsp_cfg, trsp_step, trsp_out_stage and the defines header.
`include "tile_record_stream_parser_top_defines.svh"

module tile_record_stream_parser_top #(
  parameter int unsigned SIZE_BITS  = trsp_pkg::SizeBitsDef,
  parameter int unsigned INDEX_BITS = trsp_pkg::IndexBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               first_byte_i,
  input  logic               final_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               has_byte_o,
  output logic [7:0]         payload_byte_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic               compressed_o,
  output logic [2:0]         status_o,
  output logic               last_o
);
  import trsp_pkg::*;

  cfg_t    cfg;
  result_t step_res, out_res;
  logic    step_valid;
  logic    out_free;
  logic    advance;

  logic       in_valid_q;
  logic [7:0] data_byte_q;
  logic       first_byte_q;
  logic       final_byte_q;

  trsp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_byte_q  <= data_byte_i;
      first_byte_q <= first_byte_i;
      final_byte_q <= final_byte_i;
    end
  end

  trsp_step #(
    .SIZE_BITS  (SIZE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_i       (advance),
    .data_byte_i  (data_byte_q),
    .first_byte_i (first_byte_q),
    .final_byte_i (final_byte_q),
    .res_valid_o  (step_valid),
    .res_o        (step_res)
  );

  trsp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step_valid),
    .res_i       (step_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign has_byte_o     = out_res.has_byte;
  assign payload_byte_o = out_res.payload_byte;
  assign pos_x_o        = out_res.pos_x;
  assign pos_y_o        = out_res.pos_y;
  assign compressed_o   = out_res.compressed;
  assign status_o       = out_res.status;
  assign last_o         = out_res.last;

  `TRSP_ASSERT_SAME(a_err_is_last, out_valid_o && status_o != ST_OK, last_o)
  `TRSP_ASSERT_SAME(a_mid_has_byte, out_valid_o && !last_o, has_byte_o)
  `TRSP_ASSERT_SAME(a_no_byte_zero, out_valid_o && !has_byte_o, payload_byte_o == 8'd0)
  `TRSP_ASSERT_NEXT(a_stall_holds_item, in_stall_o, in_valid_q)

endmodule
